// File: rtl/i2a_pkg.sv
// Shared types and constants of the integer to ASCII formatter.
`default_nettype none
package i2a_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int BCD_W    = DEC_DIGITS * DIGIT_W;
   localparam int REM_W    = 4;
   localparam int STEP_W   = 5;

   typedef logic [REM_W-1:0]  rem_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [CHAR_W-1:0] char_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_HEX_UPPER = 3'd0,
      OP_HEX8      = 3'd1,
      OP_HEX_MIN   = 3'd2,
      OP_POINTER   = 3'd3,
      OP_UNSIGNED  = 3'd4,
      OP_SIGNED    = 3'd5,
      OP_CHAR      = 3'd6,
      OP_NONE      = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_COUNT,
      ST_EMIT
   } state_type;

   localparam step_type LAST_STEP   = step_type'(VALUE_W - 1);
   localparam rem_type  PREFIX_LEN  = rem_type'(HEX_DIGITS + 2);
   localparam rem_type  HEX_LEN     = rem_type'(HEX_DIGITS);

   localparam char_type CHAR_ZERO    = 8'h30;
   localparam char_type CHAR_X       = 8'h78;
   localparam char_type CHAR_MINUS   = 8'h2D;
   localparam char_type CHAR_CR      = 8'h0D;
   localparam char_type CHAR_LF      = 8'h0A;
   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic load;
      logic step;
      logic set_count;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_decimal;
      logic req_skip;
      logic out_free;
      logic last_pending;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/i2a_if.sv
// Request and response channel interfaces of the formatter.
`default_nettype none
interface i2a_req_if;
   logic                         valid;
   logic                         ready;
   logic [i2a_pkg::OPCODE_W-1:0] opcode;
   logic [i2a_pkg::VALUE_W-1:0]  value;
   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface i2a_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [i2a_pkg::CHAR_W-1:0] out_char;
   logic                       last;
   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
//
// req_ch carries one item: a 3-bit format opcode and a 32-bit value.
// rsp_ch returns the item's text one character per transfer, most significant
// first, with last set on the final character (1 to 11 characters).
// Hex and char formats: accept leads straight to the emit state, which moves
// one character per cycle while rsp_ch takes them.
// Decimal formats: a double-dabble shifter converts the value, then a
// count state sizes the run before the emit state.
// One item is in work at a time; req_ch.ready is high only between runs.
// The output register lets the next item be accepted while the final
// character still waits on rsp_ch. Opcode 7 is accepted and dropped.
// When rsp_ch.ready is low the current character holds and the run pauses.
// Synchronous reset empties the output register and returns to idle.
`default_nettype none
module integer_to_ascii_formatter (
   input  wire logic  clock,
   input  wire logic  reset,
   i2a_req_if.sink    req_ch,
   i2a_rsp_if.source  rsp_ch
);

   i2a_pkg::cmd_type    cmd;
   i2a_pkg::status_type status;

   i2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2a_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_opcode   (req_ch.opcode),
      .req_value    (req_ch.value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_out_char (rsp_ch.out_char),
      .rsp_last     (rsp_ch.last)
   );

endmodule
`default_nettype wire

// File: rtl/i2a_ctrl.sv
// Controller state machine of the formatter: accept, convert, count, emit.
`default_nettype none
module i2a_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire i2a_pkg::status_type status,
   output i2a_pkg::cmd_type         cmd
);

   i2a_pkg::state_type state_ff, state_in;
   i2a_pkg::step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2a_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      unique case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_valid && !status.req_skip) begin
               state_in = status.req_decimal ? i2a_pkg::ST_CONV : i2a_pkg::ST_EMIT;
            end
         end
         i2a_pkg::ST_CONV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == i2a_pkg::LAST_STEP) begin
               state_in = i2a_pkg::ST_COUNT;
               step_in  = '0;
            end
         end
         i2a_pkg::ST_COUNT: begin
            state_in = i2a_pkg::ST_EMIT;
         end
         i2a_pkg::ST_EMIT: begin
            if (status.out_free && status.last_pending) begin
               state_in = i2a_pkg::ST_IDLE;
            end
         end
         default: state_in = i2a_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         i2a_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && !status.req_skip;
         end
         i2a_pkg::ST_CONV:  cmd.step      = 1'b1;
         i2a_pkg::ST_COUNT: cmd.set_count = 1'b1;
         i2a_pkg::ST_EMIT:  cmd.emit      = status.out_free;
         default: cmd = '0;
      endcase
   end

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != i2a_pkg::ST_CONV |-> step_ff == '0)
      else $error("step counter running outside conversion");

   a_conv_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == i2a_pkg::ST_CONV && step_ff == i2a_pkg::LAST_STEP
      |=> state_ff == i2a_pkg::ST_COUNT)
      else $error("conversion did not end after the last step");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == i2a_pkg::ST_EMIT && !status.out_free |=> state_ff == i2a_pkg::ST_EMIT)
      else $error("left emit while output stalled");

endmodule
`default_nettype wire

// File: rtl/i2a_dp.sv
// Datapath of the formatter: operand, BCD shifter, run counter, character select.
`default_nettype none
module i2a_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [i2a_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [i2a_pkg::VALUE_W-1:0]   req_value,
   input  wire i2a_pkg::cmd_type              cmd,
   output i2a_pkg::status_type                status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [i2a_pkg::CHAR_W-1:0]         rsp_out_char,
   output logic                               rsp_last
);

   i2a_pkg::opcode_type                op_ff, op_in;
   logic [i2a_pkg::VALUE_W-1:0]        work_ff, work_in;
   logic [i2a_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic                               neg_ff, neg_in;
   i2a_pkg::rem_type                   rem_ff, rem_in;
   i2a_pkg::rem_type                   digit_count_ff, digit_count_in;
   logic                               valid_ff, valid_in;
   i2a_pkg::char_type                  char_ff, char_in;
   logic                               last_ff, last_in;

   i2a_pkg::opcode_type                req_op;
   logic [i2a_pkg::BCD_W-1:0]          bcd_adj;
   i2a_pkg::rem_type                   dec_len;
   i2a_pkg::rem_type                   hex_min_len;
   logic [2:0]                         hex_idx;
   i2a_pkg::rem_type                   dec_idx;
   logic [i2a_pkg::DIGIT_W-1:0]        hex_nib;
   logic [i2a_pkg::DIGIT_W-1:0]        dec_nib;
   i2a_pkg::char_type                  char_sel;

   function automatic i2a_pkg::char_type hex_char(input logic [3:0] nib, input logic upper);
      i2a_pkg::char_type base;
      base = upper ? i2a_pkg::CHAR_UPPER_A : i2a_pkg::CHAR_LOWER_A;
      if (nib < 4'd10) begin
         hex_char = i2a_pkg::CHAR_ZERO + {4'b0, nib};
      end else begin
         hex_char = base + {4'b0, nib} - 8'd10;
      end
   endfunction

   assign req_op = i2a_pkg::opcode_type'(req_opcode);

   always_comb begin
      for (int d = 0; d < i2a_pkg::DEC_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                        : bcd_ff[d*4 +: 4];
      end
   end

   always_comb begin
      dec_len = i2a_pkg::rem_type'(1);
      for (int d = 1; d < i2a_pkg::DEC_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) dec_len = i2a_pkg::rem_type'(d + 1);
      end
      hex_min_len = i2a_pkg::rem_type'(1);
      for (int n = 1; n < i2a_pkg::HEX_DIGITS; n++) begin
         if (req_value[n*4 +: 4] != 4'd0) hex_min_len = i2a_pkg::rem_type'(n + 1);
      end
   end

   assign hex_idx = rem_ff[2:0] - 3'd1;
   assign dec_idx = rem_ff - 1'b1;
   assign hex_nib = work_ff[{hex_idx, 2'b00} +: 4];
   assign dec_nib = bcd_ff[{dec_idx, 2'b00} +: 4];

   always_comb begin
      case (op_ff) inside
         i2a_pkg::OP_HEX_UPPER, i2a_pkg::OP_POINTER: begin
            if (rem_ff == i2a_pkg::PREFIX_LEN) begin
               char_sel = i2a_pkg::CHAR_ZERO;
            end else if (rem_ff == i2a_pkg::PREFIX_LEN - 1'b1) begin
               char_sel = i2a_pkg::CHAR_X;
            end else begin
               char_sel = hex_char(hex_nib, op_ff == i2a_pkg::OP_HEX_UPPER);
            end
         end
         i2a_pkg::OP_HEX8, i2a_pkg::OP_HEX_MIN: char_sel = hex_char(hex_nib, 1'b0);
         i2a_pkg::OP_UNSIGNED, i2a_pkg::OP_SIGNED: begin
            char_sel = (rem_ff > digit_count_ff) ? i2a_pkg::CHAR_MINUS
                                                 : i2a_pkg::CHAR_ZERO + {4'b0, dec_nib};
         end
         default: char_sel = (rem_ff == i2a_pkg::rem_type'(2)) ? i2a_pkg::CHAR_CR
                                                             : work_ff[7:0];
      endcase
   end

   always_comb begin
      op_in          = op_ff;
      work_in        = work_ff;
      bcd_in         = bcd_ff;
      neg_in         = neg_ff;
      rem_in         = rem_ff;
      digit_count_in = digit_count_ff;
      if (cmd.load) begin
         op_in   = req_op;
         work_in = req_value;
         bcd_in  = '0;
         neg_in  = 1'b0;
         case (req_op) inside
            i2a_pkg::OP_HEX_UPPER, i2a_pkg::OP_POINTER: rem_in = i2a_pkg::PREFIX_LEN;
            i2a_pkg::OP_HEX8:    rem_in = i2a_pkg::HEX_LEN;
            i2a_pkg::OP_HEX_MIN: rem_in = hex_min_len;
            i2a_pkg::OP_SIGNED: begin
               rem_in = '0;
               if (req_value[i2a_pkg::VALUE_W-1]) begin
                  neg_in  = 1'b1;
                  work_in = ~req_value + 1'b1;
               end
            end
            i2a_pkg::OP_CHAR: begin
               work_in = {{(i2a_pkg::VALUE_W-8){1'b0}}, req_value[7:0]};
               rem_in  = (req_value[7:0] == i2a_pkg::CHAR_LF) ? i2a_pkg::rem_type'(2)
                                                              : i2a_pkg::rem_type'(1);
            end
            default: rem_in = '0;
         endcase
      end
      if (cmd.step) begin
         bcd_in  = {bcd_adj[i2a_pkg::BCD_W-2:0], work_ff[i2a_pkg::VALUE_W-1]};
         work_in = {work_ff[i2a_pkg::VALUE_W-2:0], 1'b0};
      end
      if (cmd.set_count) begin
         digit_count_in = dec_len;
         rem_in         = dec_len + i2a_pkg::rem_type'(neg_ff);
      end
      if (cmd.emit) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         char_in  = char_sel;
         last_in  = (rem_ff == i2a_pkg::rem_type'(1));
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
      op_ff          <= op_in;
      work_ff        <= work_in;
      bcd_ff         <= bcd_in;
      neg_ff         <= neg_in;
      digit_count_ff <= digit_count_in;
      char_ff        <= char_in;
      last_ff        <= last_in;
   end

   assign status.req_decimal  = (req_op == i2a_pkg::OP_UNSIGNED) ||
                                (req_op == i2a_pkg::OP_SIGNED);
   assign status.req_skip     = (req_op == i2a_pkg::OP_NONE);
   assign status.out_free     = !valid_ff || rsp_ready;
   assign status.last_pending = (rem_ff == i2a_pkg::rem_type'(1));

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last     = last_ff;

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rem_ff != '0)
      else $error("item emitted with empty run");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cmd.set_count |=> rem_ff != '0 && rem_ff <= i2a_pkg::rem_type'(11))
      else $error("decimal run length out of range");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> valid_ff && (last_ff == ($past(rem_ff) == i2a_pkg::rem_type'(1))))
      else $error("last flag does not match end of run");

endmodule
`default_nettype wire
